/* design/afhd_pkg.sv */
`default_nettype none
package afhd_pkg;

    localparam int CHAR_W = 8;
    localparam int POS_W  = 4;
    localparam int CNT_W  = 6;

    localparam logic [POS_W-1:0] HEADER_LEN = POS_W'(11);

    // header positions
    localparam logic [POS_W-1:0] POS_TO_MARK   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_TO_HI     = POS_W'(1);
    localparam logic [POS_W-1:0] POS_TO_LO     = POS_W'(2);
    localparam logic [POS_W-1:0] POS_FROM_MARK = POS_W'(3);
    localparam logic [POS_W-1:0] POS_FROM_HI   = POS_W'(4);
    localparam logic [POS_W-1:0] POS_FROM_LO   = POS_W'(5);
    localparam logic [POS_W-1:0] POS_TYPE_MARK = POS_W'(6);
    localparam logic [POS_W-1:0] POS_TYPE      = POS_W'(7);
    localparam logic [POS_W-1:0] POS_SEQ_HI    = POS_W'(8);
    localparam logic [POS_W-1:0] POS_SEQ_LO    = POS_W'(9);

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TO      = 8'h74;  // t
    localparam logic [CHAR_W-1:0] CH_FROM    = 8'h66;  // f
    localparam logic [CHAR_W-1:0] CH_TYPE    = 8'h70;  // p
    localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;  // :
    localparam logic [CHAR_W-1:0] CH_ACK     = 8'h41;  // A
    localparam logic [CHAR_W-1:0] CH_NEW     = 8'h4E;  // N
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_HEX_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_HEX_F   = 8'h46;

    typedef struct packed {
        logic              is_ack;
        logic [CHAR_W-1:0] source_node;
        logic [CHAR_W-1:0] sequence_res;
        logic [CHAR_W-1:0] payload_char;
        logic              last;
    } res_t;

    typedef struct packed {
        logic valid;
        res_t data;
    } res_beat_t;

    // uppercase hex digit to nibble; anything else reads as zero
    function automatic logic [3:0] hex_nibble(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        begin
            d = '0;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                d = c - CH_ZERO;
            end
            else if (c >= CH_HEX_A && c <= CH_HEX_F)
            begin
                d = c - CH_HEX_A + 8'd10;
            end
            return d[3:0];
        end
    endfunction

endpackage
`default_nettype wire

/* design/afhd_if.sv */
`default_nettype none
interface afhd_char_if import afhd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

interface afhd_res_if import afhd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              is_ack;
    logic [CHAR_W-1:0] source_node;
    logic [CHAR_W-1:0] sequence_res;
    logic [CHAR_W-1:0] payload_char;
    logic              last;

    modport source (output valid, output is_ack, output source_node, output sequence_res,
                    output payload_char, output last, input ready);
    modport sink   (input valid, input is_ack, input source_node, input sequence_res,
                    input payload_char, input last, output ready);
endinterface
`default_nettype wire

/* design/afhd_parser.sv */
`default_nettype none
module afhd_parser import afhd_pkg::*; #(
    parameter int PAYLOAD_MAX = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [CHAR_W-1:0] char_in,
    input  wire logic [CHAR_W-1:0] node_id,
    output res_beat_t              beat
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              ok_reg, ok_next;
    logic [3:0]        hi_reg, hi_next;
    logic [CHAR_W-1:0] src_reg, src_next;
    logic [CHAR_W-1:0] seq_reg, seq_next;
    logic              ack_reg, ack_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [3:0]        nib;
    logic [CHAR_W-1:0] full;

    assign nib  = hex_nibble(char_in);
    assign full = {hi_reg, nib};

    always_comb
    begin
        pos_next = pos_reg;
        ok_next  = ok_reg;
        hi_next  = hi_reg;
        src_next = src_reg;
        seq_next = seq_reg;
        ack_next = ack_reg;
        cnt_next = cnt_reg;
        beat     = '0;
        beat.data.source_node  = src_reg;
        beat.data.sequence_res = seq_reg;

        if (step && char_in != CH_NUL)
        begin
            if (char_in == CH_NEWLINE)
            begin
                // end item for an accepted line, then start over
                beat.valid       = ok_reg && pos_reg == HEADER_LEN;
                beat.data.is_ack = ack_reg;
                beat.data.last   = 1'b1;
                pos_next = '0;
                ok_next  = 1'b1;
                hi_next  = '0;
                src_next = '0;
                seq_next = '0;
                ack_next = 1'b0;
                cnt_next = '0;
            end
            else if (pos_reg == HEADER_LEN)
            begin
                if (ok_reg && !ack_reg && cnt_reg < CNT_W'(PAYLOAD_MAX))
                begin
                    beat.valid             = 1'b1;
                    beat.data.payload_char = char_in;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            else
            begin
                case (pos_reg)
                    POS_TO_MARK:   if (char_in != CH_TO) ok_next = 1'b0;
                    POS_TO_HI, POS_FROM_HI, POS_SEQ_HI: hi_next = nib;
                    POS_TO_LO:     if (full != node_id) ok_next = 1'b0;
                    POS_FROM_MARK: if (char_in != CH_FROM) ok_next = 1'b0;
                    POS_FROM_LO:   src_next = full;
                    POS_TYPE_MARK: if (char_in != CH_TYPE) ok_next = 1'b0;
                    POS_TYPE:
                    begin
                        if (char_in == CH_ACK)
                        begin
                            ack_next = 1'b1;
                        end
                        else if (char_in == CH_NEW)
                        begin
                            ack_next = 1'b0;
                        end
                        else
                        begin
                            ok_next = 1'b0;
                        end
                    end
                    POS_SEQ_LO:    seq_next = full;
                    default:       if (char_in != CH_COLON) ok_next = 1'b0;
                endcase
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ok_reg  <= 1'b1;
            hi_reg  <= '0;
            src_reg <= '0;
            seq_reg <= '0;
            ack_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            ok_reg  <= ok_next;
            hi_reg  <= hi_next;
            src_reg <= src_next;
            seq_reg <= seq_next;
            ack_reg <= ack_next;
            cnt_reg <= cnt_next;
        end
    end

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= HEADER_LEN)
        else $error("header position ran past the header");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(PAYLOAD_MAX))
        else $error("payload count above limit");

    a_newline_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && char_in == CH_NEWLINE |=> pos_reg == '0 && cnt_reg == '0 && ok_reg)
        else $error("newline did not clear line state");

    a_payload_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        beat.valid && !beat.data.last |-> pos_reg == HEADER_LEN && ok_reg && !ack_reg)
        else $error("payload item outside an accepted N line");

endmodule
`default_nettype wire

/* design/afhd_out_stage.sv */
`default_nettype none
module afhd_out_stage import afhd_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  wire res_beat_t beat,
    output logic           can_load,
    afhd_res_if.source     res
);

    logic valid_reg, valid_next;
    res_t data_reg;

    assign can_load   = !valid_reg || res.ready;
    assign valid_next = can_load ? (load && beat.valid) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load && beat.valid)
        begin
            data_reg <= beat.data;
        end
    end

    assign res.valid        = valid_reg;
    assign res.is_ack       = data_reg.is_ack;
    assign res.source_node  = data_reg.source_node;
    assign res.sequence_res = data_reg.sequence_res;
    assign res.payload_char = data_reg.payload_char;
    assign res.last         = data_reg.last;

endmodule
`default_nettype wire

/* design/ascii_frame_header_decoder.sv */
// Path: an accepted character is held in the input register; the parser step decodes it
//   combinationally and its result, if any, is loaded into the output register.
// Throughput: one character per cycle while the output register can load, set by the parser
//   step between the input register and the output register; a stalled sink holds the input.
// Reset: rst_n is asynchronous, active low; clears node_id, the line state and both valids.
`default_nettype none
module ascii_frame_header_decoder import afhd_pkg::*; #(
    parameter int PAYLOAD_MAX = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CHAR_W-1:0] cfg_wdata,
    afhd_char_if.sink              rx,
    afhd_res_if.source             res
);

    // node address register; the user must write it only while the block is idle (not enforced here)
    logic [CHAR_W-1:0] node_id_reg;

    // input register: one character waiting for the parser
    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] in_char_reg;

    logic      can_load;   // output register can take a transaction this cycle
    logic      advance;    // parser consumes the held character
    res_beat_t beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg <= '0;
        end
        else if (cfg_we)
        begin
            node_id_reg <= cfg_wdata;
        end
    end

    // The parser step runs whenever a character is held and the output register can load, so
    // the input register drains only while the result side is empty or taking a transaction.
    assign advance  = in_valid_reg && can_load;
    assign rx.ready = !in_valid_reg || can_load;

    // hold the character while stalled, otherwise take the next one (or go empty)
    assign in_valid_next = rx.ready ? rx.valid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_char_reg <= rx.rx_char;
        end
    end

    // line parser: header checks, field decode, payload count
    afhd_parser #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .char_in (in_char_reg),
        .node_id (node_id_reg),
        .beat    (beat)
    );

    // result register toward the sink
    afhd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .beat     (beat),
        .can_load (can_load),
        .res      (res)
    );

    a_stall_holds_char: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !can_load |=> in_valid_reg && $stable(in_char_reg))
        else $error("held character lost during stall");

    a_no_ready_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && res.valid && !res.ready |-> !rx.ready)
        else $error("input taken while both stages are blocked");

    a_result_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) && !$past(res.valid) |-> !res.valid)
        else $error("result transaction without a parser step");

endmodule
`default_nettype wire

/* sim/ascii_frame_header_decoder_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module ascii_frame_header_decoder_tb;
    import afhd_pkg::*;

    localparam int PAYLOAD_LIMIT = 32;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CHAR_W-1:0] cfg_wdata;

    afhd_char_if rx_if ();
    afhd_res_if  res_if ();

    ascii_frame_header_decoder #(
        .PAYLOAD_MAX(PAYLOAD_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .rx(rx_if),
        .res(res_if)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Characters waiting to be offered, and the beats the parser should give back
    logic [CHAR_W-1:0] rx_backlog [$];
    res_t              predicted_beats [$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   queued_count  = 0;
    int   mismatch_count = 0;
    logic char_taken = 1'b0;
    logic recv_hold = 1'b0;
    logic pressure_armed = 1'b0;
    logic [CHAR_W-1:0] node_setting = '0;

    // Parser state as the decoder should hold it
    logic [CHAR_W-1:0] my_node;
    logic [6:0]        hdr_pos;
    logic              line_ok;
    logic [3:0]        hi_nib;
    logic [CHAR_W-1:0] dest_addr;
    logic [CHAR_W-1:0] src_addr;
    logic [CHAR_W-1:0] seq_num;
    logic              ack_line;
    logic [CNT_W-1:0]  pay_cnt;

    function automatic logic [3:0] nibble_of(input logic [CHAR_W-1:0] c);
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
                return c[3:0];
            if (c >= CH_HEX_A && c <= CH_HEX_F)
                return c[3:0] + 4'd9;
            return 4'd0;
        end
    endfunction

    function automatic void clear_line();
        hdr_pos   = '0;
        line_ok   = 1'b1;
        hi_nib    = '0;
        dest_addr = '0;
        src_addr  = '0;
        seq_num   = '0;
        ack_line  = 1'b0;
        pay_cnt   = '0;
    endfunction

    // Advance the parser by one accepted character; queue the beat it yields, if any
    task automatic parse_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] full;
        res_t beat;
        begin
            full = {hi_nib, nibble_of(c)};
            beat = '0;
            // a NUL never moves the line
            if (c == CH_NEWLINE)
            begin
                // short lines and any mismatch give nothing; newline always clears
                if (line_ok && hdr_pos >= HEADER_LEN)
                begin
                    beat.is_ack       = ack_line;
                    beat.source_node  = src_addr;
                    beat.sequence_res = seq_num;
                    beat.last         = 1'b1;
                    predicted_beats.push_back(beat);
                end
                clear_line();
            end
            else if (c != CH_NUL && hdr_pos >= HEADER_LEN)
            begin
                // payload: pass on N lines up to the limit, drop the rest
                if (line_ok && !ack_line && pay_cnt < PAYLOAD_LIMIT)
                begin
                    pay_cnt           = pay_cnt + 1'b1;
                    beat.source_node  = src_addr;
                    beat.sequence_res = seq_num;
                    beat.payload_char = c;
                    predicted_beats.push_back(beat);
                end
            end
            else if (c != CH_NUL)
            begin
                case (hdr_pos)
                    POS_TO_MARK:   line_ok = line_ok && (c == CH_TO);
                    POS_TO_HI,
                    POS_FROM_HI,
                    POS_SEQ_HI:    hi_nib = nibble_of(c);
                    POS_TO_LO:
                    begin
                        // address compared against node_id as it stands right now
                        dest_addr = full;
                        line_ok   = line_ok && (full == my_node);
                    end
                    POS_FROM_MARK: line_ok = line_ok && (c == CH_FROM);
                    POS_FROM_LO:   src_addr = full;
                    POS_TYPE_MARK: line_ok = line_ok && (c == CH_TYPE);
                    POS_TYPE:
                    begin
                        if (c == CH_ACK)
                            ack_line = 1'b1;
                        else if (c == CH_NEW)
                            ack_line = 1'b0;
                        else
                            line_ok = 1'b0;
                    end
                    POS_SEQ_LO:    seq_num = full;
                    default:       line_ok = line_ok && (c == CH_COLON);
                endcase
                hdr_pos = hdr_pos + 1'b1;
            end
        end
    endtask

    // Compare one delivered beat against the oldest prediction
    task automatic check_beat(input res_t got);
        res_t want;
        begin
            if (predicted_beats.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected beat: ack=%0d src=%02h seq=%02h char=%02h last=%0d",
                             got.is_ack, got.source_node, got.sequence_res,
                             got.payload_char, got.last);
            end
            else
            begin
                want = predicted_beats.pop_front();
                if (got.is_ack !== want.is_ack || got.source_node !== want.source_node ||
                    got.sequence_res !== want.sequence_res ||
                    got.payload_char !== want.payload_char || got.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: exp ack=%0d src=%02h seq=%02h char=%02h last=%0d",
                                 want.is_ack, want.source_node, want.sequence_res,
                                 want.payload_char, want.last,
                                 " / got ack=%0d src=%02h seq=%02h char=%02h last=%0d",
                                 got.is_ack, got.source_node, got.sequence_res,
                                 got.payload_char, got.last);
                end
            end
        end
    endtask

    // Monitor: sample every transaction at the rising edge, predict on input, check on output
    always @(posedge clk)
    begin
        char_taken <= rst_n && rx_if.valid && rx_if.ready;
        if (rst_n)
        begin
            if (cfg_we)
                my_node = cfg_wdata;
            if (rx_if.valid && rx_if.ready)
                parse_char(rx_if.rx_char);
            if (res_if.valid && res_if.ready)
                check_beat(res_t'{res_if.is_ack, res_if.source_node, res_if.sequence_res,
                                  res_if.payload_char, res_if.last});
        end
    end

    // Driver: at the falling edge hold the current character until taken, then advance
    always @(negedge clk)
    begin
        if (!rx_if.valid || char_taken)
        begin
            if (rst_n && rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                rx_if.valid   <= 1'b1;
                rx_if.rx_char <= rx_backlog.pop_front();
            end
            else
            begin
                rx_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: drop ready at random, or for the whole of a long hold
    always @(negedge clk)
    begin
        res_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long hold-off on the result side while characters keep coming, to back up the input
    initial
    begin
        wait (pressure_armed);
        repeat (25) @(negedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        recv_hold <= 1'b0;
    end

    function automatic logic [CHAR_W-1:0] rand_char();
        logic [CHAR_W-1:0] c;
        begin
            do
                c = CHAR_W'($urandom_range(1, 255));
            while (c == CH_NEWLINE);
            return c;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? CH_ZERO + n : CH_HEX_A + n - 8'd10;
    endfunction

    // Queue one character, now and then preceded by a stray NUL that does not count
    task automatic put_char(input logic [CHAR_W-1:0] c);
        begin
            if ($urandom_range(39) == 0)
                rx_backlog.push_back(CH_NUL);
            rx_backlog.push_back(c);
            queued_count++;
        end
    endtask

    task automatic push_text(input string s);
        begin
            for (int i = 0; i < s.len(); i++)
                rx_backlog.push_back(s[i]);
        end
    endtask

    // Build one frame: mostly well formed, sometimes with a bad digit, a bad character
    // or a truncated header
    task automatic queue_frame();
        logic [CHAR_W-1:0] hdr [0:10];
        logic [CHAR_W-1:0] to_addr;
        logic [CHAR_W-1:0] from_addr;
        logic [CHAR_W-1:0] seq_no;
        int pick;
        int plen;
        int cut;
        begin
            to_addr   = ($urandom_range(4) == 0) ? CHAR_W'($urandom_range(255)) : node_setting;
            from_addr = CHAR_W'($urandom_range(255));
            seq_no    = CHAR_W'($urandom_range(255));
            pick      = $urandom_range(19);
            hdr[POS_TO_MARK]   = CH_TO;
            hdr[POS_TO_HI]     = hex_char(to_addr[7:4]);
            hdr[POS_TO_LO]     = hex_char(to_addr[3:0]);
            hdr[POS_FROM_MARK] = CH_FROM;
            hdr[POS_FROM_HI]   = hex_char(from_addr[7:4]);
            hdr[POS_FROM_LO]   = hex_char(from_addr[3:0]);
            hdr[POS_TYPE_MARK] = CH_TYPE;
            hdr[POS_TYPE]      = (pick < 13) ? CH_NEW : (pick < 18) ? CH_ACK : rand_char();
            hdr[POS_SEQ_HI]    = hex_char(seq_no[7:4]);
            hdr[POS_SEQ_LO]    = hex_char(seq_no[3:0]);
            hdr[HEADER_LEN-1]  = CH_COLON;
            // swap a digit for lowercase hex, which reads as nibble zero, or for junk
            for (int k = 0; k < HEADER_LEN - 1; k++)
            begin
                if (k != POS_TO_MARK && k != POS_FROM_MARK && k != POS_TYPE_MARK &&
                    k != POS_TYPE && $urandom_range(24) == 0)
                    hdr[k] = $urandom_range(1) ? CH_LOWER_A + CHAR_W'($urandom_range(5))
                                               : rand_char();
            end
            if ($urandom_range(7) == 0)
                hdr[$urandom_range(HEADER_LEN - 1)] = rand_char();
            cut = ($urandom_range(14) == 0) ? $urandom_range(HEADER_LEN - 1) : HEADER_LEN;
            for (int k = 0; k < cut; k++)
                put_char(hdr[k]);
            if (cut == HEADER_LEN)
            begin
                // mostly short payloads, a few running past the limit
                plen = ($urandom_range(9) == 0) ? $urandom_range(PAYLOAD_LIMIT - 4,
                                                                 PAYLOAD_LIMIT + 8)
                                                : $urandom_range(8);
                for (int k = 0; k < plen; k++)
                    put_char(rand_char());
            end
            put_char(CH_NEWLINE);
        end
    endtask

    // Random junk, sometimes left open so that it runs into the next frame
    task automatic queue_noise();
        int n;
        begin
            n = $urandom_range(1, 12);
            for (int k = 0; k < n; k++)
                put_char(rand_char());
            if ($urandom_range(1))
                put_char(CH_NEWLINE);
        end
    endtask

    task automatic fill_random(input int target);
        begin
            queued_count = 0;
            while (queued_count < target)
            begin
                if ($urandom_range(9) != 0)
                    queue_frame();
                else
                    queue_noise();
            end
        end
    endtask

    // Hold until every character is in and every predicted beat is out, then let
    // the pipeline settle
    task automatic wait_drained();
        begin
            do
            begin
                @(posedge clk);
                #1;
            end
            while (rx_backlog.size() != 0 || rx_if.valid || predicted_beats.size() != 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_node(input logic [CHAR_W-1:0] v);
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= v;
            node_setting = v;
            @(negedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    initial
    begin
        rx_if.valid   = 1'b0;
        rx_if.rx_char = '0;
        res_if.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        my_node       = '0;
        clear_line();

        send_idle_pct = 14;
        recv_idle_pct = 65;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: node 0 from reset; N line with extreme payload bytes and a NUL,
        // A line whose payload must vanish, then a short line
        push_text("t00fFFpN7F:");
        rx_backlog.push_back(8'hFF);
        rx_backlog.push_back(8'h01);
        rx_backlog.push_back(CH_NUL);
        rx_backlog.push_back(CH_NEWLINE);
        push_text("t00f00pA00:Q");
        rx_backlog.push_back(CH_NEWLINE);
        push_text("tf");
        rx_backlog.push_back(CH_NEWLINE);
        wait_drained();

        // Busy sender, slow receiver: dense input, choked output
        write_node(8'hFF);
        fill_random(400);
        wait_drained();

        send_idle_pct = 65;
        recv_idle_pct = 14;
        write_node(CHAR_W'($urandom_range(1, 254)));
        fill_random(400);
        wait_drained();

        // Full rate both ways, with one long receiver hold in the middle
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_node(8'h00);
        fill_random(450);
        pressure_armed = 1'b1;
        wait_drained();

        if (mismatch_count == 0 && predicted_beats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
